### src/json_token_stream_parser_unit_assert.svh
// Assertion macros for the JSON tokenizer checker.
// Included by the checker file only.
`ifndef JSON_TOKEN_STREAM_PARSER_UNIT_ASSERT_SVH
`define JSON_TOKEN_STREAM_PARSER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define JTSP_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication.
`define JTSP_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

### src/jtsp_pkg.sv
// Package for the JSON tokenizer: payload types, mode codes, constants.
// No dependencies.
package jtsp_pkg;
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic [2:0]         value_kind;
    logic               bool_value;
    logic signed [63:0] int_value;
    logic signed [63:0] fixed_value;
    logic [31:0]        text_start;
    logic [31:0]        text_length;
    logic [31:0]        key_start;
    logic [31:0]        key_length;
    logic signed [15:0] nest_depth;
    logic [1:0]         error_code;
  } out_item_t;

  localparam logic [1:0] EV_VALUE = 2'd0;
  localparam logic [1:0] EV_END   = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  localparam logic [2:0] VK_NULL = 3'd0;
  localparam logic [2:0] VK_BOOL = 3'd1;
  localparam logic [2:0] VK_NUM  = 3'd2;
  localparam logic [2:0] VK_STR  = 3'd3;
  localparam logic [2:0] VK_OBJ  = 3'd4;
  localparam logic [2:0] VK_ARR  = 3'd5;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_END   = 2'd1;
  localparam logic [1:0] ERR_TOKEN = 2'd2;

  localparam logic [4:0] M_START      = 5'd0;
  localparam logic [4:0] M_STR1       = 5'd1;
  localparam logic [4:0] M_AFTER_STR1 = 5'd2;
  localparam logic [4:0] M_VALUE2     = 5'd3;
  localparam logic [4:0] M_STR2       = 5'd4;
  localparam logic [4:0] M_AFTER_END  = 5'd5;
  localparam logic [4:0] M_NUM_INT    = 5'd6;
  localparam logic [4:0] M_NUM_FRAC   = 5'd7;
  localparam logic [4:0] M_NUM_ESIGN  = 5'd8;
  localparam logic [4:0] M_NUM_EXP    = 5'd9;
  localparam logic [4:0] M_LIT_TRUE   = 5'd10;
  localparam logic [4:0] M_LIT_FALSE  = 5'd11;
  localparam logic [4:0] M_LIT_NULL   = 5'd12;
  localparam logic [4:0] M_POST_NULL  = 5'd13;
  localparam logic [4:0] M_POST_TRUE  = 5'd14;
  localparam logic [4:0] M_POST_FALSE = 5'd15;
  localparam logic [4:0] M_POST_NUM   = 5'd16;
  localparam logic [4:0] M_POST_STR   = 5'd17;
  localparam logic [4:0] M_POST_OBJ   = 5'd18;
  localparam logic [4:0] M_POST_ARR   = 5'd19;

  localparam logic [63:0] SAT_MAG = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
  localparam logic [63:0] SAT_DIV10 = SAT_MAG / 64'd10;

  // datapath commands from the controller
  typedef enum logic [3:0] {
    DC_NONE, DC_START_NUM, DC_INT_DIGIT, DC_FRAC_DIV, DC_FRAC_ADD,
    DC_EXP_DIGIT, DC_SCALE_PREP, DC_SCALE_STEP, DC_SCALE_DONE, DC_CLEAR
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [3:0] digit;
    logic       set_neg;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_sts_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] lit_char(input logic [4:0] m, input logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (m)
      M_LIT_TRUE:  case (i) 3'd1: r = "r"; 3'd2: r = "u"; 3'd3: r = "e"; default: r = 8'h00; endcase
      M_LIT_FALSE: case (i) 3'd1: r = "a"; 3'd2: r = "l"; 3'd3: r = "s"; 3'd4: r = "e";
                     default: r = 8'h00; endcase
      default:     case (i) 3'd1: r = "u"; 3'd2: r = "l"; 3'd3: r = "l"; default: r = 8'h00; endcase
    endcase
    return r;
  endfunction
endpackage

### src/jtsp_datapath.sv
// Number datapath: integer and Q31.32 accumulators, exponent scaling.
// Depends on jtsp_pkg. One multiply by ten per cycle; a divide by ten steps through front, mid and fix.
module jtsp_datapath #(
  parameter int MAX_EXPONENT = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jtsp_pkg::dp_cmd_t cmd_i,
  output jtsp_pkg::dp_sts_t sts_o,
  output logic [63:0]       int_o,
  output logic [63:0]       fixed_o
);
  import jtsp_pkg::*;

  localparam int EW = $clog2(MAX_EXPONENT + 1) + 1;
  localparam logic [EW-1:0] EMAX = EW'(MAX_EXPONENT);

  // phases of one divide by ten
  localparam logic [1:0] D_FRONT = 2'd0, D_MID = 2'd1, D_FIX = 2'd2;

  logic [63:0]   int_q, int_d, fix_q, fix_d, qi_q, qi_d, qf_q, qf_d;
  logic [3:0]    fk_q, fk_d;
  logic [1:0]    dph_q, dph_d;
  logic [EW-1:0] exp_q, exp_d, cnt_q, cnt_d;
  logic          neg_q, neg_d, eneg_q, eneg_d, ineg_q, ineg_d;
  logic [63:0]   add, dadd;
  logic [36:0]   prod;
  logic [67:0]   fx10;
  logic [EW+3:0] etmp;

  // fraction weight after k digits: floor(2^32 / 10^k)
  function automatic logic [32:0] frac_wt(input logic [3:0] k);
    logic [32:0] w;
    case (k)
      4'd0:    w = ONE_Q32[32:0];
      4'd1:    w = 33'd429496729;
      4'd2:    w = 33'd42949672;
      4'd3:    w = 33'd4294967;
      4'd4:    w = 33'd429496;
      4'd5:    w = 33'd42949;
      4'd6:    w = 33'd4294;
      4'd7:    w = 33'd429;
      4'd8:    w = 33'd42;
      4'd9:    w = 33'd4;
      default: w = '0;
    endcase
    return w;
  endfunction

  // x * 0.8 by shift and add, first part
  function automatic logic [63:0] d10_front(input logic [63:0] x);
    logic [63:0] q;
    q = (x >> 1) + (x >> 2);
    return q + (q >> 4);
  endfunction

  function automatic logic [63:0] d10_mid(input logic [63:0] q0);
    logic [63:0] q;
    q = q0 + (q0 >> 8);
    q = q + (q >> 16);
    return q + (q >> 32);
  endfunction

  // scale down and correct the low estimate from the remainder
  function automatic logic [63:0] d10_fix(input logic [63:0] x, input logic [63:0] qp);
    logic [63:0] q, r;
    q = qp >> 3;
    r = x - ((q << 3) + (q << 1));
    if (r > 64'd19) q = q + 64'd2;
    else if (r > 64'd9) q = q + 64'd1;
    return q;
  endfunction

  always_comb begin
    int_d = int_q; fix_d = fix_q; fk_d = fk_q; exp_d = exp_q; cnt_d = cnt_q;
    neg_d = neg_q; eneg_d = eneg_q; ineg_d = ineg_q;
    qi_d = qi_q; qf_d = qf_q; dph_d = dph_q;
    add  = {28'd0, cmd_i.digit, 32'd0};
    prod = frac_wt(fk_q) * {33'd0, cmd_i.digit};
    dadd = {27'd0, prod};
    fx10 = {4'd0, fix_q} * 68'd10 + {4'd0, add};
    etmp = {4'd0, exp_q} * (EW+4)'(10) + (EW+4)'(cmd_i.digit);
    unique case (cmd_i.op)
      DC_CLEAR, DC_START_NUM: begin
        int_d = '0; fix_d = '0; fk_d = '0; exp_d = '0; cnt_d = '0; dph_d = D_FRONT;
        neg_d = cmd_i.set_neg; eneg_d = 1'b0;
      end
      DC_INT_DIGIT: begin
        int_d = int_q * 64'd10 + {60'd0, cmd_i.digit};
        fix_d = (fx10 > {4'd0, SAT_MAG}) ? SAT_MAG : fx10[63:0];
      end
      DC_FRAC_DIV: if (fk_q != 4'd10) fk_d = fk_q + 4'd1;
      DC_FRAC_ADD: fix_d = (fix_q > SAT_MAG - dadd) ? SAT_MAG : fix_q + dadd;
      DC_EXP_DIGIT: begin
        if (cmd_i.set_neg) eneg_d = 1'b1;
        else exp_d = (etmp > (EW+4)'(EMAX)) ? EMAX : etmp[EW-1:0];
      end
      DC_SCALE_PREP: begin
        cnt_d = exp_q; dph_d = D_FRONT;
        int_d = neg_q ? 64'd0 - int_q : int_q;
        ineg_d = int_d[63];
        if (eneg_q && int_d[63]) int_d = 64'd0 - int_d;
      end
      DC_SCALE_STEP: begin
        if (cnt_q != '0) begin
          if (eneg_q) begin
            unique case (dph_q)
              D_FRONT: begin
                qi_d = d10_front(int_q); qf_d = d10_front(fix_q); dph_d = D_MID;
              end
              D_MID: begin
                qi_d = d10_mid(qi_q); qf_d = d10_mid(qf_q); dph_d = D_FIX;
              end
              default: begin
                int_d = d10_fix(int_q, qi_q); fix_d = d10_fix(fix_q, qf_q);
                dph_d = D_FRONT; cnt_d = cnt_q - 1'b1;
              end
            endcase
          end else begin
            cnt_d = cnt_q - 1'b1;
            int_d = int_q * 64'd10;
            fix_d = (fix_q > SAT_DIV10) ? SAT_MAG : fix_q * 64'd10;
          end
        end
      end
      DC_SCALE_DONE: begin
        if (eneg_q && ineg_q) int_d = 64'd0 - int_q;
        if (neg_q) fix_d = 64'd0 - fix_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q <= '0; fix_q <= '0; fk_q <= '0; exp_q <= '0; cnt_q <= '0;
      neg_q <= 1'b0; eneg_q <= 1'b0; ineg_q <= 1'b0;
      qi_q <= '0; qf_q <= '0; dph_q <= D_FRONT;
    end else begin
      int_q <= int_d; fix_q <= fix_d; fk_q <= fk_d; exp_q <= exp_d; cnt_q <= cnt_d;
      neg_q <= neg_d; eneg_q <= eneg_d; ineg_q <= ineg_d;
      qi_q <= qi_d; qf_q <= qf_d; dph_q <= dph_d;
    end
  end

  assign sts_o.busy = (cnt_q != '0);
  assign int_o   = int_q;
  assign fixed_o = fix_q;
endmodule

### src/jtsp_controller.sv
// Tokenizer controller: scan mode machine, spans, depth, result queue.
// Depends on jtsp_pkg; drives jtsp_datapath through dp_cmd_t.
module jtsp_controller #(
  parameter int POSITION_BITS = 32,
  parameter int DEPTH_BITS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jtsp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jtsp_pkg::out_item_t out_item_o,
  output jtsp_pkg::dp_cmd_t   cmd_o,
  input  jtsp_pkg::dp_sts_t   sts_i,
  input  logic [63:0]         int_i,
  input  logic [63:0]         fixed_i
);
  import jtsp_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam int DW = DEPTH_BITS;
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  // phases of the sequencer
  localparam logic [2:0] P_IDLE = 3'd0, P_WORK = 3'd1, P_FRAC = 3'd2, P_SCALE = 3'd3,
                         P_SDONE = 3'd4, P_LAST = 3'd5, P_OUT = 3'd6;

  logic [2:0]           ph_q, ph_d;
  logic [4:0]           mode_q, mode_d;
  logic [PW-1:0]        pos_q, pos_d, sst_q, sst_d, slen_q, slen_d;
  logic [31:0]          ks_q, ks_d, kl_q, kl_d;
  logic signed [DW-1:0] dep_q, dep_d;
  logic [2:0]           lit_q, lit_d;
  logic [1:0]           err_q, err_d;
  logic [7:0]           c_q, c_d;
  logic                 last_q, last_d;
  out_item_t            res_q [2];
  out_item_t            res_d [2];
  logic [1:0]           cnt_q, cnt_d;
  logic                 rd_q, rd_d;
  logic [2:0]           pass_q, pass_d;
  logic [7:0]           c;
  logic signed [DW:0]   dsum;
  out_item_t            ev;
  logic                 push, again;

  assign in_ready_o  = (ph_q == P_IDLE);
  assign out_valid_o = (ph_q == P_OUT);
  assign out_item_o  = res_q[rd_q];

  always_comb begin
    ph_d = ph_q; mode_d = mode_q; pos_d = pos_q; sst_d = sst_q; slen_d = slen_q;
    ks_d = ks_q; kl_d = kl_q; dep_d = dep_q; lit_d = lit_q; err_d = err_q;
    c_d = c_q; last_d = last_q; res_d = res_q; cnt_d = cnt_q; rd_d = rd_q;
    pass_d = pass_q;
    cmd_o = '{op: DC_NONE, digit: 4'd0, set_neg: 1'b0};
    c = c_q; push = 1'b0; again = 1'b0; dsum = '0;
    ev = '0;
    unique case (ph_q)
      P_IDLE: if (in_valid_i && err_q == ERR_NONE) begin
        c_d = in_item_i.byte_in; last_d = in_item_i.last_byte;
        cnt_d = '0; rd_d = 1'b0; pass_d = '0; ph_d = P_WORK;
      end
      P_WORK: begin
        ph_d = P_LAST;
        case (mode_q)
          M_START, M_VALUE2: if (!is_ws(c)) begin
            if (c == "\"") begin
              sst_d = pos_q + 1'b1; slen_d = '0;
              mode_d = (mode_q == M_START) ? M_STR1 : M_STR2;
            end else if (c == "{" || c == "[") begin
              dsum = (DW+1)'(dep_q) + (DW+1)'(1);
              dep_d = (dsum > DMAX) ? DMAX : dsum[DW-1:0];
              mode_d = (c == "{") ? M_POST_OBJ : M_POST_ARR;
            end else if (c == "]" || c == "}") begin
              dsum = (DW+1)'(dep_q) - (DW+1)'(1);
              dep_d = (dsum < DMIN) ? DMIN : dsum[DW-1:0];
              push = 1'b1; ev.event_res = EV_END; mode_d = M_AFTER_END;
            end else if (c == "-") begin
              cmd_o.op = DC_START_NUM; cmd_o.set_neg = 1'b1; mode_d = M_NUM_INT;
            end else if (is_dig(c)) begin
              cmd_o.op = DC_START_NUM; mode_d = M_NUM_INT; ph_d = P_FRAC;
            end else if (c == "t" || c == "f" || c == "n") begin
              lit_d = 3'd1;
              mode_d = (c == "t") ? M_LIT_TRUE : (c == "f") ? M_LIT_FALSE : M_LIT_NULL;
            end else begin
              push = 1'b1; ev.event_res = EV_ERROR; ev.error_code = ERR_TOKEN;
              err_d = ERR_TOKEN;
            end
          end
          M_STR1, M_STR2:
            if (c == "\"") mode_d = (mode_q == M_STR1) ? M_AFTER_STR1 : M_POST_STR;
            else slen_d = slen_q + 1'b1;
          M_AFTER_END: if (!is_ws(c)) begin
            mode_d = M_START; again = (c != ",");
          end
          M_NUM_INT:
            if (is_dig(c)) begin
              cmd_o.op = DC_INT_DIGIT; cmd_o.digit = c[3:0];
            end else if (c == ".") mode_d = M_NUM_FRAC;
            else if (c == "e" || c == "E") mode_d = M_NUM_ESIGN;
            else begin cmd_o.op = DC_SCALE_PREP; ph_d = P_SCALE; end
          M_NUM_FRAC:
            if (is_dig(c)) begin cmd_o.op = DC_FRAC_DIV; ph_d = P_FRAC; end
            else if (c == "e" || c == "E") mode_d = M_NUM_ESIGN;
            else begin cmd_o.op = DC_SCALE_PREP; ph_d = P_SCALE; end
          M_NUM_ESIGN, M_NUM_EXP:
            if (mode_q == M_NUM_ESIGN && (c == "+" || c == "-")) begin
              if (c == "-") begin cmd_o.op = DC_EXP_DIGIT; cmd_o.set_neg = 1'b1; end
              mode_d = M_NUM_EXP;
            end else if (is_dig(c)) begin
              cmd_o.op = DC_EXP_DIGIT; cmd_o.digit = c[3:0]; mode_d = M_NUM_EXP;
            end else begin cmd_o.op = DC_SCALE_PREP; ph_d = P_SCALE; end
          M_LIT_TRUE, M_LIT_FALSE, M_LIT_NULL:
            if (c != lit_char(mode_q, lit_q)) begin
              push = 1'b1; ev.event_res = EV_ERROR; ev.error_code = ERR_TOKEN;
              err_d = ERR_TOKEN;
            end else if ((mode_q == M_LIT_FALSE && lit_q == 3'd4) ||
                         (mode_q != M_LIT_FALSE && lit_q == 3'd3)) begin
              lit_d = '0;
              mode_d = (mode_q == M_LIT_TRUE) ? M_POST_TRUE :
                       (mode_q == M_LIT_FALSE) ? M_POST_FALSE : M_POST_NULL;
            end else lit_d = lit_q + 1'b1;
          M_AFTER_STR1, M_POST_NULL, M_POST_TRUE, M_POST_FALSE, M_POST_NUM,
          M_POST_STR, M_POST_OBJ, M_POST_ARR: if (!is_ws(c)) begin
            if (mode_q == M_AFTER_STR1 && c == ":") begin
              ks_d = 32'(sst_q); kl_d = 32'(slen_q); mode_d = M_VALUE2;
            end else begin
              push = 1'b1; ev.event_res = EV_VALUE;
              case (mode_q)
                M_POST_NULL:  ev.value_kind = VK_NULL;
                M_POST_TRUE:  begin ev.value_kind = VK_BOOL; ev.bool_value = 1'b1; end
                M_POST_FALSE: ev.value_kind = VK_BOOL;
                M_POST_NUM:   begin
                  ev.value_kind = VK_NUM; ev.int_value = int_i; ev.fixed_value = fixed_i;
                end
                M_POST_OBJ:   ev.value_kind = VK_OBJ;
                M_POST_ARR:   ev.value_kind = VK_ARR;
                default: begin
                  ev.value_kind = VK_STR; ev.text_start = 32'(sst_q);
                  ev.text_length = 32'(slen_q);
                end
              endcase
              mode_d = M_START; again = (c != ",");
            end
          end
          default: begin mode_d = M_START; again = 1'b1; end
        endcase
        if (again && err_d == ERR_NONE) ph_d = P_WORK;
      end
      P_FRAC: begin
        // follow-up phase of a digit: add to fraction or integer
        if (mode_q == M_NUM_FRAC) cmd_o.op = DC_FRAC_ADD;
        else cmd_o.op = DC_INT_DIGIT;
        cmd_o.digit = c[3:0];
        ph_d = P_LAST;
      end
      P_SCALE: begin
        cmd_o.op = DC_SCALE_STEP;
        if (!sts_i.busy) ph_d = P_SDONE;
      end
      P_SDONE: begin
        cmd_o.op = DC_SCALE_DONE; mode_d = M_POST_NUM; ph_d = P_WORK;
      end
      P_LAST: begin
        ph_d = P_OUT;
        if (err_q == ERR_NONE) begin
          pos_d = pos_q + 1'b1;
          if (last_q) begin
            if (mode_q == M_START || mode_q == M_AFTER_END) begin
              mode_d = M_START; pos_d = '0; dep_d = '0; lit_d = '0; sst_d = '0;
              slen_d = '0; ks_d = '0; kl_d = '0; cmd_o.op = DC_CLEAR;
            end else begin
              push = 1'b1; ev.event_res = EV_ERROR;
              ev.error_code = (mode_q == M_LIT_TRUE || mode_q == M_LIT_FALSE ||
                               mode_q == M_LIT_NULL) ? ERR_TOKEN : ERR_END;
              err_d = ev.error_code;
            end
          end
        end
        if (cnt_q == '0 && !push) ph_d = P_IDLE;
      end
      P_OUT: if (out_ready_i) begin
        if (rd_q == 1'b0 && cnt_q == 2'd2) rd_d = 1'b1;
        else ph_d = P_IDLE;
      end
      default: ph_d = P_IDLE;
    endcase
    if (push && cnt_q != 2'd2) begin
      ev.key_start = ks_q; ev.key_length = kl_q;
      ev.nest_depth = 16'(dep_d);
      res_d[cnt_q[0]] = ev; cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= P_IDLE; mode_q <= M_START; pos_q <= '0; sst_q <= '0; slen_q <= '0;
      ks_q <= '0; kl_q <= '0; dep_q <= '0; lit_q <= '0; err_q <= ERR_NONE;
      cnt_q <= '0; rd_q <= 1'b0; last_q <= 1'b0; pass_q <= '0;
    end else begin
      ph_q <= ph_d; mode_q <= mode_d; pos_q <= pos_d; sst_q <= sst_d; slen_q <= slen_d;
      ks_q <= ks_d; kl_q <= kl_d; dep_q <= dep_d; lit_q <= lit_d; err_q <= err_d;
      cnt_q <= cnt_d; rd_q <= rd_d; last_q <= last_d; pass_q <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    res_q <= res_d;
  end
endmodule

### src/json_token_stream_parser_unit.sv
// Top level of the JSON pull tokenizer.
// Depends on jtsp_pkg, jtsp_controller and jtsp_datapath.
//
//  channel | direction | handshake                 | payload
//  input   | in        | in_valid_i / in_ready_o   | in_item_i  (byte, last mark)
//  output  | out       | out_valid_o / out_ready_i | out_item_o (one event)
//
// An item passes accept, scan and close phases, plus output of each event it
// returns and another scan pass when the byte is looked at again; a digit that
// starts a number and each fraction digit add a digit-add phase. The byte that
// ends a number adds x10 scaling, or /10 scaling when the exponent is negative.
// Reset is asynchronous, active low, and returns the parser to document start.
// Hold input while events wait; after an error, accept and drop items until reset.
module json_token_stream_parser_unit #(
  parameter int POSITION_BITS = 32,
  parameter int DEPTH_BITS    = 16,
  parameter int MAX_EXPONENT  = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jtsp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jtsp_pkg::out_item_t out_item_o
);
  import jtsp_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [63:0] int_v, fix_v;

  // sequencer: walks each byte through the scan modes
  jtsp_controller #(.POSITION_BITS(POSITION_BITS), .DEPTH_BITS(DEPTH_BITS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .cmd_o(cmd), .sts_i(sts), .int_i(int_v), .fixed_i(fix_v)
  );

  // number accumulators and exponent scaling
  jtsp_datapath #(.MAX_EXPONENT(MAX_EXPONENT)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .int_o(int_v), .fixed_o(fix_v)
  );
endmodule

### src/jtsp_checker.sv
// Port-level checker for the JSON tokenizer, bound to the top level.
// Depends on jtsp_pkg and the assertion macro header.
`include "json_token_stream_parser_unit_assert.svh"
module jtsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input jtsp_pkg::out_item_t out_item_o
);
  import jtsp_pkg::*;

  logic err_shown, err_taken, out_wait;

  assign err_shown = out_valid_o && out_item_o.event_res == EV_ERROR;
  assign err_taken = err_shown && out_ready_i;
  assign out_wait  = out_valid_o && !out_ready_i;

  // an item is never taken while a result waits
  `JTSP_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o)
  // an error result carries a real code
  `JTSP_ASSERT_IMP(a_err_code, clk_i, rst_ni, err_shown, out_item_o.error_code != ERR_NONE)
  // the error is the last result
  `JTSP_ASSERT_NXT(a_sticky, clk_i, rst_ni, err_taken, !out_valid_o)
  // hold a waiting result unchanged
  `JTSP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_item_o))
endmodule

bind json_token_stream_parser_unit jtsp_checker u_chk (.*);

### bench/tb.sv
// Self-checking bench for json_token_stream_parser_unit: drives JSON documents byte by byte
// and checks every emitted event against a behavioural tokenizer model kept in the bench.
// Depends on jtsp_pkg (payload structs, event, kind and error codes).
`timescale 1ns / 100ps

module tb;
  import jtsp_pkg::*;

  localparam int MAX_EXP     = 24;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 120;
  localparam int HOLD_CYCLES = 400;
  localparam logic [63:0] MAG_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

  // scanner modes of the bench's own tokenizer
  typedef enum logic [4:0] {
    S_START, S_KEY_STR, S_AFTER_KEY, S_MEMBER_VAL, S_VAL_STR, S_AFTER_CLOSE,
    S_INT, S_FRAC, S_EXP_SIGN, S_EXP, S_LIT_T, S_LIT_F, S_LIT_N,
    S_HAVE_NULL, S_HAVE_TRUE, S_HAVE_FALSE, S_HAVE_NUM, S_HAVE_STR, S_HAVE_OBJ, S_HAVE_ARR
  } scan_e;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_item;

  json_token_stream_parser_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer model state
  // ---------------------------------------------------------------------------
  scan_e              tok_mode;
  logic [31:0]        tok_pos;
  logic signed [15:0] tok_depth;
  logic [63:0]        int_acc;
  logic [63:0]        fix_acc;
  logic [63:0]        frac_weight;
  int unsigned        exp_acc;
  logic [1:0]         neg_flags;   // bit 0 negative number, bit 1 negative exponent
  int                 lit_idx;
  logic [31:0]        str_start;
  logic [31:0]        str_len;
  logic [31:0]        key_start;
  logic [31:0]        key_len;
  logic [1:0]         err_latch;
  int                 step_events;

  out_item_t expected_events[$];
  int        mismatches;
  int        shown;
  int        tx_idle_pct;
  int        rx_idle_pct;
  logic      rx_hold_req;

  function automatic void clear_tokenizer();
    tok_mode    = S_START;
    tok_pos     = '0;
    tok_depth   = '0;
    int_acc     = '0;
    fix_acc     = '0;
    frac_weight = 64'h1_0000_0000;
    exp_acc     = 0;
    neg_flags   = '0;
    lit_idx     = 0;
    str_start   = '0;
    str_len     = '0;
    key_start   = '0;
    key_len     = '0;
    err_latch   = ERR_NONE;
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // queue one event; at most two per byte
  function automatic void post_event(input logic [1:0] ev, input logic [2:0] kind,
                                     input logic bv, input logic [63:0] iv,
                                     input logic [63:0] fv, input logic [31:0] ts,
                                     input logic [31:0] tl, input logic [1:0] err);
    out_item_t e;
    if (step_events >= 2) return;
    e.event_res   = ev;
    e.value_kind  = kind;
    e.bool_value  = bv;
    e.int_value   = iv;
    e.fixed_value = fv;
    e.text_start  = ts;
    e.text_length = tl;
    e.key_start   = key_start;
    e.key_length  = key_len;
    e.nest_depth  = tok_depth;
    e.error_code  = err;
    expected_events.push_back(e);
    step_events++;
  endfunction

  function automatic void flag_error(input logic [1:0] code);
    err_latch = code;
    post_event(EV_ERROR, VK_NULL, 1'b0, '0, '0, '0, '0, code);
  endfunction

  function automatic void bump_depth(input int d);
    int v;
    v = int'(tok_depth) + d;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    tok_depth = v[15:0];
  endfunction

  function automatic void int_digit(input int d);
    logic [63:0] add;
    add = 64'(d) << 32;
    int_acc = int_acc * 64'd10 + 64'(d);
    if (fix_acc > (MAG_CAP - add) / 64'd10) fix_acc = MAG_CAP;
    else fix_acc = fix_acc * 64'd10 + add;
  endfunction

  function automatic void begin_number();
    int_acc     = '0;
    fix_acc     = '0;
    frac_weight = 64'h1_0000_0000;
    exp_acc     = 0;
    neg_flags   = '0;
    tok_mode    = S_INT;
  endfunction

  // apply sign and exponent to both accumulators
  function automatic void close_number();
    logic [63:0] iv;
    logic [63:0] mag;
    logic [63:0] m;
    logic        neg;
    iv  = neg_flags[0] ? -int_acc : int_acc;
    mag = fix_acc;
    if (neg_flags[1]) begin
      neg = iv[63];
      m = neg ? -iv : iv;
      for (int i = 0; i < int'(exp_acc); i++) begin
        m   = m / 64'd10;
        mag = mag / 64'd10;
      end
      iv = neg ? -m : m;
    end else begin
      for (int i = 0; i < int'(exp_acc); i++) begin
        iv  = iv * 64'd10;
        mag = (mag > MAG_CAP / 64'd10) ? MAG_CAP : mag * 64'd10;
      end
    end
    int_acc  = iv;
    fix_acc  = neg_flags[0] ? -mag : mag;
    tok_mode = S_HAVE_NUM;
  endfunction

  function automatic void start_token(input logic [7:0] c);
    if (c == "{") begin
      bump_depth(1);
      tok_mode = S_HAVE_OBJ;
    end else if (c == "[") begin
      bump_depth(1);
      tok_mode = S_HAVE_ARR;
    end else if (c == "]" || c == "}") begin
      bump_depth(-1);
      post_event(EV_END, VK_NULL, 1'b0, '0, '0, '0, '0, ERR_NONE);
      tok_mode = S_AFTER_CLOSE;
    end else if (c == "-") begin
      begin_number();
      neg_flags = 2'b01;
    end else if (digit(c)) begin
      begin_number();
      int_digit(int'(c) - 48);
    end else if (c == "t" || c == "f" || c == "n") begin
      lit_idx  = 1;
      tok_mode = (c == "t") ? S_LIT_T : (c == "f") ? S_LIT_F : S_LIT_N;
    end else begin
      flag_error(ERR_TOKEN);
    end
  endfunction

  function automatic void release_pending();
    case (tok_mode)
      S_HAVE_NULL:  post_event(EV_VALUE, VK_NULL, 1'b0, '0, '0, '0, '0, ERR_NONE);
      S_HAVE_TRUE:  post_event(EV_VALUE, VK_BOOL, 1'b1, '0, '0, '0, '0, ERR_NONE);
      S_HAVE_FALSE: post_event(EV_VALUE, VK_BOOL, 1'b0, '0, '0, '0, '0, ERR_NONE);
      S_HAVE_NUM:   post_event(EV_VALUE, VK_NUM, 1'b0, int_acc, fix_acc, '0, '0, ERR_NONE);
      S_HAVE_OBJ:   post_event(EV_VALUE, VK_OBJ, 1'b0, '0, '0, '0, '0, ERR_NONE);
      S_HAVE_ARR:   post_event(EV_VALUE, VK_ARR, 1'b0, '0, '0, '0, '0, ERR_NONE);
      default:      post_event(EV_VALUE, VK_STR, 1'b0, '0, '0, str_start, str_len, ERR_NONE);
    endcase
  endfunction

  // one pass over a byte; returns 1 when the same byte must be looked at again
  function automatic logic scan_byte(input logic [7:0] c);
    string word;
    scan_e done_mode;
    logic [63:0] add;
    case (tok_mode)
      S_START, S_MEMBER_VAL: begin
        if (blank(c)) return 1'b0;
        if (c == 8'h22) begin
          str_start = tok_pos + 32'd1;
          str_len   = '0;
          tok_mode  = (tok_mode == S_START) ? S_KEY_STR : S_VAL_STR;
        end else begin
          start_token(c);
        end
        return 1'b0;
      end
      S_KEY_STR, S_VAL_STR: begin
        if (c == 8'h22) tok_mode = (tok_mode == S_KEY_STR) ? S_AFTER_KEY : S_HAVE_STR;
        else str_len = str_len + 32'd1;
        return 1'b0;
      end
      S_AFTER_CLOSE: begin
        if (blank(c)) return 1'b0;
        tok_mode = S_START;
        return c != ",";
      end
      S_INT: begin
        if (digit(c)) begin
          int_digit(int'(c) - 48);
          return 1'b0;
        end
        if (c == ".") begin
          tok_mode = S_FRAC;
          return 1'b0;
        end
        if (c == "e" || c == "E") begin
          tok_mode = S_EXP_SIGN;
          return 1'b0;
        end
        close_number();
        return 1'b1;
      end
      S_FRAC: begin
        if (digit(c)) begin
          frac_weight = frac_weight / 64'd10;
          add = frac_weight * 64'(int'(c) - 48);
          fix_acc = (fix_acc > MAG_CAP - add) ? MAG_CAP : fix_acc + add;
          return 1'b0;
        end
        if (c == "e" || c == "E") begin
          tok_mode = S_EXP_SIGN;
          return 1'b0;
        end
        close_number();
        return 1'b1;
      end
      S_EXP_SIGN, S_EXP: begin
        if (tok_mode == S_EXP_SIGN && (c == "+" || c == "-")) begin
          if (c == "-") neg_flags[1] = 1'b1;
          tok_mode = S_EXP;
          return 1'b0;
        end
        if (digit(c)) begin
          exp_acc = exp_acc * 10 + (int'(c) - 48);
          if (exp_acc > MAX_EXP) exp_acc = MAX_EXP;
          tok_mode = S_EXP;
          return 1'b0;
        end
        close_number();
        return 1'b1;
      end
      S_LIT_T, S_LIT_F, S_LIT_N: begin
        if (tok_mode == S_LIT_T) begin
          word = "true";
          done_mode = S_HAVE_TRUE;
        end else if (tok_mode == S_LIT_F) begin
          word = "false";
          done_mode = S_HAVE_FALSE;
        end else begin
          word = "null";
          done_mode = S_HAVE_NULL;
        end
        if (lit_idx >= word.len() || c != word[lit_idx]) begin
          flag_error(ERR_TOKEN);
          return 1'b0;
        end
        lit_idx++;
        if (lit_idx == word.len()) begin
          lit_idx  = 0;
          tok_mode = done_mode;
        end
        return 1'b0;
      end
      default: begin
        // a finished value waits for its next non-blank byte
        if (blank(c)) return 1'b0;
        if (tok_mode == S_AFTER_KEY && c == ":") begin
          key_start = str_start;
          key_len   = str_len;
          tok_mode  = S_MEMBER_VAL;
          return 1'b0;
        end
        release_pending();
        tok_mode = S_START;
        return c != ",";
      end
    endcase
  endfunction

  // work out the events that one accepted byte causes
  function automatic void predict_events(input logic [7:0] c, input logic last);
    step_events = 0;
    if (err_latch != ERR_NONE) return;
    for (int p = 0; p < 4; p++) begin
      if (!scan_byte(c) || err_latch != ERR_NONE) break;
    end
    if (err_latch != ERR_NONE) return;
    tok_pos = tok_pos + 32'd1;
    if (last) begin
      if (tok_mode == S_START || tok_mode == S_AFTER_CLOSE) clear_tokenizer();
      else if (tok_mode inside {S_LIT_T, S_LIT_F, S_LIT_N}) flag_error(ERR_TOKEN);
      else flag_error(ERR_END);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Document generator: JSON-like text with random content
  // ---------------------------------------------------------------------------
  function automatic void add_blank(ref logic [7:0] q[$]);
    logic [7:0] pick [6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
    if ($urandom_range(99) < 30) q.push_back(pick[$urandom_range(5)]);
  endfunction

  function automatic void add_string(ref logic [7:0] q[$]);
    logic [7:0] b;
    q.push_back(8'h22);
    repeat ($urandom_range(6)) begin
      do b = 8'($urandom); while (b == 8'h22);
      q.push_back(b);
    end
    q.push_back(8'h22);
  endfunction

  function automatic void add_digits(ref logic [7:0] q[$], input int n);
    repeat (n) q.push_back(8'("0" + $urandom_range(9)));
  endfunction

  function automatic void add_number(ref logic [7:0] q[$]);
    if ($urandom_range(2) == 0) q.push_back("-");
    // mostly short integers, sometimes long enough to saturate, sometimes none
    case ($urandom_range(9))
      0:       add_digits(q, 0);
      1, 2:    add_digits(q, $urandom_range(10, 21));
      default: add_digits(q, $urandom_range(1, 4));
    endcase
    if ($urandom_range(2) == 0) begin
      q.push_back(".");
      add_digits(q, $urandom_range(0, 12));
    end
    if ($urandom_range(2) == 0) begin
      q.push_back($urandom_range(1) ? "e" : "E");
      case ($urandom_range(2))
        0: q.push_back("+");
        1: q.push_back("-");
        default: ;
      endcase
      add_digits(q, $urandom_range(0, 3));
    end
  endfunction

  function automatic void add_value(ref logic [7:0] q[$], input int lvl);
    int n;
    case ((lvl > 3) ? $urandom_range(4) : $urandom_range(7))
      0: begin q.push_back("n"); q.push_back("u"); q.push_back("l"); q.push_back("l"); end
      1: begin q.push_back("t"); q.push_back("r"); q.push_back("u"); q.push_back("e"); end
      2: begin
        q.push_back("f"); q.push_back("a"); q.push_back("l"); q.push_back("s");
        q.push_back("e");
      end
      4: add_string(q);
      5: begin
        q.push_back("[");
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) q.push_back(",");
          add_blank(q);
          add_value(q, lvl + 1);
          add_blank(q);
        end
        q.push_back("]");
      end
      6: begin
        q.push_back("{");
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) q.push_back(",");
          add_blank(q);
          add_string(q);
          add_blank(q);
          q.push_back(":");
          add_blank(q);
          add_value(q, lvl + 1);
          add_blank(q);
        end
        q.push_back("}");
      end
      default: add_number(q);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // offer one item, hold it until taken, then sometimes drop valid and idle
  task automatic send_item(input logic [7:0] b, input logic last);
    in_item  <= '{byte_in: b, last_byte: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_events(b, last);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // send a byte string as a document; the final byte carries the last mark
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  task automatic send_doc(input logic [7:0] q[$]);
    foreach (q[i]) send_item(q[i], i == q.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold_req) begin
        // hold off long enough for the block to back up and stall its input
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          if (shown < 10) begin
            shown++;
            $display("unexpected event: %p", out_item);
          end
        end else begin
          out_item_t want;
          want = expected_events.pop_front();
          if (out_item.event_res   !== want.event_res   ||
              out_item.value_kind  !== want.value_kind  ||
              out_item.bool_value  !== want.bool_value  ||
              out_item.int_value   !== want.int_value   ||
              out_item.fixed_value !== want.fixed_value ||
              out_item.text_start  !== want.text_start  ||
              out_item.text_length !== want.text_length ||
              out_item.key_start   !== want.key_start   ||
              out_item.key_length  !== want.key_length  ||
              out_item.nest_depth  !== want.nest_depth  ||
              out_item.error_code  !== want.error_code) begin
            mismatches++;
            if (shown < 10) begin
              shown++;
              $display("event mismatch\n  expected %p\n  actual   %p", want, out_item);
            end
          end
        end
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // short hand-picked documents: sign, fraction, signed exponent, key, every
  // literal, an empty container and a stray closer
  string directed_docs [3] = '{
    "{\"k\":-9.5e+1,\"t\":true}",
    "[null,false,[]]",
    "],"
  };

  initial begin
    logic [7:0] doc[$];
    int sent;
    int docs;
    int phase_len;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    rx_hold_req = 1'b0;
    mismatches  = 0;
    shown       = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    clear_tokenizer();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_docs[i]) send_text(directed_docs[i]);

    // random documents in three idling phases
    sent = 0;
    docs = 0;
    phase_len = 460;
    while (sent < 1400) begin
      if (sent < phase_len) begin
        tx_idle_pct = 37;
        rx_idle_pct = 55;
      end else if (sent < 2 * phase_len) begin
        tx_idle_pct = 55;
        rx_idle_pct = 37;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // back-pressure: the receiver stops while bytes keep coming
      if (docs == 25) rx_hold_req = 1'b1;
      // pause the sender until every outstanding event has arrived
      if (docs == 50) begin
        in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge clk);
      end
      doc.delete();
      repeat ($urandom_range(1, 3)) begin
        add_blank(doc);
        if ($urandom_range(19) == 0) doc.push_back("]");
        else add_value(doc, 0);
        add_blank(doc);
        doc.push_back(",");
      end
      // sometimes end on a container closer rather than a comma
      if ($urandom_range(3) == 0) begin
        doc.pop_back();
        doc.push_back("[");
        doc.push_back("]");
      end
      send_doc(doc);
      sent += doc.size();
      docs++;
    end

    // the error is sticky, so the document that provokes one comes last
    case ($urandom_range(3))
      0:       send_text("[tru");
      1:       send_text("[1,x");
      2:       send_text("{\"a\":12");
      default: send_text("\"open");
    endcase
    in_valid <= 1'b0;

    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
